FILE: src/lpc_pkg.sv
package lpc_pkg;

	localparam int ENTRIES   = 16;
	localparam int PAGE_BITS = 32;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CAP_W  = 5;
	localparam int OCC_W  = 5;
	localparam int IN_W   = 32;
	localparam int OUT_W  = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef logic [PAGE_BITS-1:0] page_t;

	// Broadcast from the control logic to every cell of the row.
	typedef struct packed {
		logic             load;
		logic             hit;
		logic [IDX_W-1:0] last;
	} cell_ctl_t;

endpackage

FILE: src/lpc_cell.sv
module lpc_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [lpc_pkg::IDX_W-1:0] idx,
	input  lpc_pkg::page_t           page,
	input  lpc_pkg::page_t           up_page,
	input  logic                     up_chain,
	input  lpc_pkg::cell_ctl_t       ctl,
	output lpc_pkg::page_t           page_out,
	output logic                     valid_out,
	output logic                     match,
	output logic                     chain_out
);

	lpc_pkg::page_t page_q;
	logic           valid_q;
	logic           shift;

	assign match     = valid_q && (page_q == page);
	assign chain_out = up_chain | match;
	assign page_out  = page_q;
	assign valid_out = valid_q;

	// On a hit only the cells above the matching one move down; on a miss
	// every cell up to the new least-recent slot moves down.
	assign shift = ctl.hit ? !up_chain : (idx <= ctl.last);

	always_ff @(posedge clk) begin
		if (ctl.load && shift) begin
			page_q <= up_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load && !ctl.hit) begin
			valid_q <= (idx <= ctl.last);
		end
	end

endmodule

FILE: src/lru_page_cache.sv
// Fully associative LRU page cache. Each request on the s_ side carries one
// page number; each result on the m_ side reports a hit flag and the number
// of pages held after the access. The pages sit in a row of cells ordered
// from most recent to least recent; every cell compares its page in the same
// cycle and a match ripples down the row to decide which cells shift. One
// request is taken per clock cycle unless a result waits unaccepted in the
// output register, where each result is registered; the tag compare plus the
// ripple through all ENTRIES cells sets the clock period. The capacity register
// may be written only while no request is in flight; values of zero act as one
// and values above the built depth act as the depth.
module lru_page_cache (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lpc_pkg::CAP_W-1:0]  cfg_wdata,   // capacity
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [lpc_pkg::IN_W-1:0]   s_tdata,     // [31:0] page_number
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [lpc_pkg::OUT_W-1:0]  m_tdata      // [0] hit, [5:1] occupancy, [7:6] zero
);

	logic [lpc_pkg::CAP_W-1:0] capacity_q;
	logic [lpc_pkg::CNT_W-1:0] fill_count_q;
	logic                      m_tvalid_q;
	logic                      hit_q;
	logic [lpc_pkg::OCC_W-1:0] occupancy_q;

	lpc_pkg::page_t            page_in;
	lpc_pkg::page_t            page_chain [lpc_pkg::ENTRIES+1];
	logic [lpc_pkg::ENTRIES:0] chain;
	logic [lpc_pkg::ENTRIES-1:0] valid_vec;
	logic [lpc_pkg::ENTRIES-1:0] match_vec;
	lpc_pkg::cell_ctl_t        ctl;

	logic                      accept;
	logic                      hit;
	logic [lpc_pkg::CNT_W-1:0] eff_cap;
	logic [lpc_pkg::CNT_W-1:0] last_slot;
	logic [lpc_pkg::CNT_W-1:0] fill_next;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign page_in  = lpc_pkg::PAGE_BITS'(s_tdata);

	assign page_chain[0] = page_in;
	assign chain[0]      = 1'b0;

	genvar k;
	generate
		for (k = 0; k < lpc_pkg::ENTRIES; k++) begin : g_cell
			lpc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.idx       (lpc_pkg::IDX_W'(k)),
				.page      (page_in),
				.up_page   (page_chain[k]),
				.up_chain  (chain[k]),
				.ctl       (ctl),
				.page_out  (page_chain[k+1]),
				.valid_out (valid_vec[k]),
				.match     (match_vec[k]),
				.chain_out (chain[k+1])
			);
		end
	endgenerate

	assign hit = chain[lpc_pkg::ENTRIES];

	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = lpc_pkg::CNT_W'(1);
		end else if (int'(capacity_q) > lpc_pkg::ENTRIES) begin
			eff_cap = lpc_pkg::CNT_W'(lpc_pkg::ENTRIES);
		end else begin
			eff_cap = lpc_pkg::CNT_W'(capacity_q);
		end
		// A miss with the cache full (or over a lowered capacity) drops the
		// least recent pages so that the shifted row ends at the last usable slot.
		if (fill_count_q >= eff_cap) begin
			last_slot = eff_cap - lpc_pkg::CNT_W'(1);
		end else begin
			last_slot = fill_count_q;
		end
		fill_next = hit ? fill_count_q : last_slot + lpc_pkg::CNT_W'(1);
	end

	assign ctl.load = accept;
	assign ctl.hit  = hit;
	assign ctl.last = lpc_pkg::IDX_W'(last_slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= lpc_pkg::CAP_RESET;
			fill_count_q <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (accept) begin
				fill_count_q <= fill_next;
				m_tvalid_q   <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q       <= hit;
			occupancy_q <= lpc_pkg::OCC_W'(fill_next);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(lpc_pkg::OUT_W - lpc_pkg::OCC_W - 1)'(0), occupancy_q, hit_q};

	// Valid cells always form a prefix whose length is the fill count.
	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(fill_count_q))
		else $error("valid cells disagree with fill count");

	// A page is held in at most one cell.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("page matched in more than one cell");

	// A hit leaves the occupancy unchanged.
	a_hit_keeps_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && hit |=> fill_count_q == $past(fill_count_q))
		else $error("hit changed occupancy");

	// After any request the cache holds at least one page.
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> fill_count_q != '0 && valid_vec[0])
		else $error("cache empty after a request");

	// The reported occupancy never exceeds the built depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_count_q) <= lpc_pkg::ENTRIES)
		else $error("fill count beyond depth");

endmodule

FILE: test/tb_lru_page_cache.sv
`timescale 1ns / 1ps

module tb_lru_page_cache;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 140;

	typedef struct packed {
		logic                     hit;
		logic [lpc_pkg::OCC_W-1:0] occupancy;
	} lookup_result_t;

	// Mirrors the recency row and predicts hit and occupancy for each accepted request.
	class lru_result_tracker;
		lpc_pkg::page_t            recency[lpc_pkg::ENTRIES];
		int                        held;
		logic [lpc_pkg::CAP_W-1:0] capacity;
		lookup_result_t            due_results[$];
		int                        mismatches;

		function new();
			held = 0;
			capacity = lpc_pkg::CAP_RESET;
			mismatches = 0;
		endfunction

		function void set_capacity(logic [lpc_pkg::CAP_W-1:0] value);
			capacity = value;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%t: %s", $realtime, msg);
			end
		endfunction

		function lookup_result_t predict_lookup(lpc_pkg::page_t page);
			lookup_result_t r;
			int             found;
			int             limit;
			int             k;
			found = -1;
			for (k = 0; k < held; k++) begin
				if (recency[k] == page) begin
					found = k;
					break;
				end
			end
			if (found >= 0) begin
				for (k = found; k > 0; k--) recency[k] = recency[k-1];
				r.hit = 1'b1;
			end else begin
				limit = (capacity == 0) ? 1 :
					(capacity > lpc_pkg::ENTRIES) ? lpc_pkg::ENTRIES : int'(capacity);
				// A lowered capacity trims the oldest pages only when a miss comes in.
				if (held >= limit) held = limit - 1;
				for (k = held; k > 0; k--) recency[k] = recency[k-1];
				held++;
				r.hit = 1'b0;
			end
			recency[0] = page;
			r.occupancy = lpc_pkg::OCC_W'(held);
			return r;
		endfunction

		function void note_request(lpc_pkg::page_t page);
			due_results.push_back(predict_lookup(page));
		endfunction

		function void check_result(logic [lpc_pkg::OUT_W-1:0] data);
			lookup_result_t want;
			if (due_results.size() == 0) begin
				flag($sformatf("result 0x%h with no request pending", data));
				return;
			end
			want = due_results.pop_front();
			if (data[0] !== want.hit) begin
				flag($sformatf("hit: expected %0d, got %0d", want.hit, data[0]));
			end
			if (data[lpc_pkg::OCC_W:1] !== want.occupancy) begin
				flag($sformatf("occupancy: expected %0d, got %0d", want.occupancy,
					data[lpc_pkg::OCC_W:1]));
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [lpc_pkg::CAP_W-1:0]   cfg_wdata = '0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [lpc_pkg::IN_W-1:0]    s_tdata = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [lpc_pkg::OUT_W-1:0]   m_tdata;

	lru_result_tracker           tracker = new();
	logic [lpc_pkg::CAP_W-1:0]   cur_cap = lpc_pkg::CAP_RESET;
	bit                          quiet = 1'b0;
	int                          hold_token = 0;
	int                          hold_seen = 0;
	int                          hold_left = 0;
	lpc_pkg::page_t              last_page = '0;

	lru_page_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Result side: random stalls, plus a long hold-off whenever the token moves.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(99) >= 15);
		end
	end

	// Inputs change only at rising edges, so mid-cycle values show the coming transfer.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) tracker.check_result(m_tdata);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("** lru_page_cache: FAILED **");
		$finish;
	end

	task automatic send_page(input lpc_pkg::page_t page);
		s_tvalid <= 1'b1;
		s_tdata <= page;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		tracker.note_request(page);
		last_page = page;
		if (!quiet && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [lpc_pkg::CAP_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_capacity(value);
		cur_cap = value;
	endtask

	task automatic run_random(input int count);
		lpc_pkg::page_t pool[$];
		lpc_pkg::page_t page;
		int             eff;
		int             pick;
		int             bitpos;
		eff = (cur_cap == 0) ? 1 :
			(cur_cap > lpc_pkg::ENTRIES) ? lpc_pkg::ENTRIES : int'(cur_cap);
		// A pool of the capacity plus up to four pages gives a mix of hits and evictions.
		repeat (eff + $urandom_range(0, 4)) pool.push_back($urandom());
		repeat (count) begin
			pick = $urandom_range(99);
			bitpos = $urandom_range(lpc_pkg::PAGE_BITS - 1);
			if (pick < 75) begin
				page = pool[$urandom_range(pool.size() - 1)];
			end else if (pick < 87) begin
				page = $urandom();
			end else if (pick < 95) begin
				case ($urandom_range(3))
					0: page = '0;
					1: page = '1;
					2: page = lpc_pkg::page_t'(1) << bitpos;
					default: page = ~(lpc_pkg::page_t'(1) << bitpos);
				endcase
			end else begin
				page = last_page;
			end
			send_page(page);
		end
	endtask

	initial begin
		logic [lpc_pkg::CAP_W-1:0] phase_caps[10];
		int                        p;
		phase_caps = '{5'd3, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd12, 5'd16, 5'd5, 5'd16};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Repeats of the extreme pages, first at the reset capacity.
		send_page(32'h0000_0000);
		send_page(32'h0000_0000);
		send_page(32'hFFFF_FFFF);
		send_page(32'h8000_0000);
		send_page(32'h0000_0001);
		send_page(32'hFFFF_FFFF);
		// With room for two pages, the third distinct page pushes out the oldest.
		write_capacity(5'd2);
		send_page(32'h1234_5678);
		send_page(32'h9ABC_DEF0);
		send_page(32'h0F0F_0F0F);
		send_page(32'h1234_5678);
		write_capacity(5'd16);
		run_random(PHASE_ITEMS);

		for (p = 0; p < 10; p++) begin
			// The first write lowers the capacity below a full cache.
			write_capacity(phase_caps[p]);
			quiet = (p == 4);
			if (p == 2) hold_token <= hold_token + 1;
			if (p == 3) begin
				run_random(PHASE_ITEMS / 2);
				drain();
				run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				run_random(PHASE_ITEMS);
			end
		end
		quiet = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("** lru_page_cache: PASSED **");
		end else begin
			$display("** lru_page_cache: FAILED **");
		end
		$finish;
	end

endmodule

FILE: lru_page_cache.f
src/lpc_pkg.sv
src/lpc_cell.sv
src/lru_page_cache.sv
test/tb_lru_page_cache.sv
